/* hw/rtl/fifo_queue_remove_by_id_assert.svh */
// Assertion macros shared by the queue RTL.
`ifndef FIFO_QUEUE_REMOVE_BY_ID_ASSERT_SVH
`define FIFO_QUEUE_REMOVE_BY_ID_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define FQR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define FQR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FQR_ASSERT(lbl, prop, msg)
`define FQR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/fqr_pkg.sv */
// Types and constants for the order-keeping record queue.
`timescale 1ns / 1ps
`default_nettype none
package fqr_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		ACT_ENQUEUE = 2'd0,
		ACT_DEQUEUE = 2'd1,
		ACT_REMOVE  = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} fsm_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
		logic [1:0]  pstate;
	} rec_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] proc_id;
		logic [7:0]  proc_priority;
		logic [1:0]  proc_state;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_id;
		logic [7:0]  out_priority;
		logic [1:0]  out_state;
		logic [4:0]  entry_count;
	} out_word_t;

	// broadcast to every cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/fifo_queue_remove_by_id.sv */
// Top level: record queue with remove-by-id, control sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_queue_remove_by_id_assert.svh"
// Order-keeping queue of {id, priority, state} records held in a row of QUEUE_DEPTH cells,
// cell 0 being the head. Every accepted word gives exactly one result word. Enqueue,
// dequeue and the unused action code finish at the accept edge: the result shows the next
// cycle and a new word can be taken every cycle as long as results are taken. Remove walks
// the cells from the head one per cycle with a scan counter, pausing while a finished result
// waits stalled, and holds the input until the first match from the head is found or no
// held record matches. On a hit the cells at and behind the match all shift one place toward
// the head together. No word is taken while a finished result waits stalled.
// entry_count carries the low five bits of the occupancy.
module fifo_queue_remove_by_id #(
	parameter int QUEUE_DEPTH = fqr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  fqr_pkg::in_word_t  req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output fqr_pkg::out_word_t rsp
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	fqr_pkg::fsm_t      state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   scan_q, scan_d;
	logic [15:0]        search_q, search_d;
	logic               rsp_valid_q;
	fqr_pkg::out_word_t rsp_q, rsp_d;
	logic               rsp_load;
	logic               out_free;
	logic               req_acc;
	fqr_pkg::cell_cmd_t cmd;
	logic [IDX_W-1:0]   shift_from;
	fqr_pkg::rec_t      new_rec;
	fqr_pkg::rec_t      rec_vec [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] match_vec;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != fqr_pkg::S_IDLE) || !out_free;
	assign req_acc   = req_valid && !req_stall;

	assign new_rec.id     = req.proc_id;
	assign new_rec.prio   = req.proc_priority;
	assign new_rec.pstate = req.proc_state;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		fqr_pkg::rec_t nxt;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = rec_vec[i];
		end else begin : g_mid
			assign nxt = rec_vec[i + 1];
		end
		fqr_cell #(
			.QUEUE_DEPTH(QUEUE_DEPTH),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.shift_from(shift_from),
			.new_rec   (new_rec),
			.next_rec  (nxt),
			.search_id (search_q),
			.rec       (rec_vec[i]),
			.match     (match_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqr_pkg::S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			scan_q  <= scan_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		search_q <= search_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		scan_d     = scan_q;
		search_d   = search_q;
		cmd        = '0;
		shift_from = '0;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		unique case (state_q)
			fqr_pkg::S_IDLE: begin
				if (req_acc) begin
					unique case (fqr_pkg::action_t'(req.action))
						fqr_pkg::ACT_ENQUEUE: begin
							rsp_load = 1'b1;
							if (count_q == DEPTH_C) begin
								rsp_d.status = fqr_pkg::ST_FULL;
							end else begin
								cmd.load = 1'b1;
								count_d  = count_q + CNT_W'(1);
							end
						end
						fqr_pkg::ACT_DEQUEUE: begin
							rsp_load = 1'b1;
							if (count_q == '0) begin
								rsp_d.status = fqr_pkg::ST_EMPTY;
							end else begin
								rsp_d.out_id       = rec_vec[0].id;
								rsp_d.out_priority = rec_vec[0].prio;
								rsp_d.out_state    = rec_vec[0].pstate;
								cmd.shift          = 1'b1;
								count_d            = count_q - CNT_W'(1);
							end
						end
						fqr_pkg::ACT_REMOVE: begin
							search_d = req.proc_id;
							scan_d   = '0;
							state_d  = fqr_pkg::S_SCAN;
						end
						fqr_pkg::ACT_NONE: begin
							rsp_load = 1'b1;
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
					rsp_d.status = (fqr_pkg::action_t'(req.action) == fqr_pkg::ACT_ENQUEUE &&
						count_q == DEPTH_C) ? fqr_pkg::ST_FULL :
						(fqr_pkg::action_t'(req.action) == fqr_pkg::ACT_DEQUEUE &&
						count_q == '0) ? fqr_pkg::ST_EMPTY : fqr_pkg::ST_OK;
				end
			end
			fqr_pkg::S_SCAN: begin
				if (out_free) begin
					if (scan_q == count_q) begin
						rsp_load     = 1'b1;
						rsp_d.status = fqr_pkg::ST_NOT_FOUND;
						state_d      = fqr_pkg::S_IDLE;
					end else if (match_vec[scan_q[IDX_W-1:0]]) begin
						cmd.shift    = 1'b1;
						shift_from   = scan_q[IDX_W-1:0];
						count_d      = count_q - CNT_W'(1);
						rsp_load     = 1'b1;
						rsp_d.status = fqr_pkg::ST_OK;
						state_d      = fqr_pkg::S_IDLE;
					end else begin
						scan_d = scan_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = fqr_pkg::S_IDLE;
			end
		endcase
		rsp_d.entry_count = 5'(count_d);
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`FQR_ASSERT(a_count_bound, (count_q <= DEPTH_C), "occupancy above depth")
	`FQR_ASSERT(a_scan_bound, (state_q == fqr_pkg::S_SCAN) |-> (scan_q <= count_q),
		"scan index past tail")
	`FQR_ASSERT(a_enq_count,
		(req_acc && req.action == fqr_pkg::ACT_ENQUEUE && count_q != DEPTH_C) |=>
		(count_q == $past(count_q) + CNT_W'(1)), "enqueue did not grow count")
	`FQR_ASSERT(a_hit_count,
		(state_q == fqr_pkg::S_SCAN && out_free && scan_q != count_q &&
		match_vec[scan_q[IDX_W-1:0]]) |=> (count_q == $past(count_q) - CNT_W'(1)),
		"remove did not shrink count")
	`FQR_ASSERT_ALWAYS(a_empty_count,
		(rsp_valid_q && rsp_q.status == fqr_pkg::ST_EMPTY) |-> (rsp_q.entry_count == 5'd0),
		"empty status with nonzero count")

endmodule
`default_nettype wire

/* hw/rtl/fqr_cell.sv */
// One slot of the record chain: holds a record, loads at the tail, shifts toward the head.
`timescale 1ns / 1ps
`default_nettype none
module fqr_cell #(
	parameter int QUEUE_DEPTH = fqr_pkg::QUEUE_DEPTH_DEF,
	parameter int IDX = 0
) (
	input  wire                               clk,
	input  fqr_pkg::cell_cmd_t                cmd,
	input  wire [$clog2(QUEUE_DEPTH+1)-1:0]   count,
	input  wire [$clog2(QUEUE_DEPTH)-1:0]     shift_from,
	input  fqr_pkg::rec_t                     new_rec,
	input  fqr_pkg::rec_t                     next_rec,
	input  wire [15:0]                        search_id,
	output fqr_pkg::rec_t                     rec,
	output logic                              match
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	fqr_pkg::rec_t rec_q;

	// load when this slot is the first free one; shift when at or past the removed slot
	always_ff @(posedge clk) begin
		if (cmd.load && (count == CNT_W'(IDX))) begin
			rec_q <= new_rec;
		end else if (cmd.shift && (IDX_W'(IDX) >= shift_from)) begin
			rec_q <= next_rec;
		end
	end

	assign rec   = rec_q;
	assign match = (rec_q.id == search_id);

endmodule
`default_nettype wire

/* tb/sv/record_queue_check.sv */
// Checker for the record queue: tracks accepted words, predicts each result, compares.
`timescale 1ns / 1ps
module record_queue_check #(
	parameter int QUEUE_DEPTH = fqr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	input  wire                req_stall,
	input  fqr_pkg::in_word_t  req,
	input  wire                rsp_valid,
	input  wire                rsp_stall,
	input  fqr_pkg::out_word_t rsp,
	output int                 errors,
	output int                 due_count,
	output int                 results_seen,
	output int                 full_hits,
	output int                 empty_hits,
	output int                 remove_hits,
	output int                 remove_misses
);

	fqr_pkg::rec_t      held_records[$];
	fqr_pkg::out_word_t due_results[$];

	// applies one word to the shadow queue, returns the result it must produce
	function automatic fqr_pkg::out_word_t apply_word(input fqr_pkg::in_word_t w);
		fqr_pkg::out_word_t r;
		fqr_pkg::rec_t      rec;
		int                 hit;
		r = '0;
		r.status = fqr_pkg::ST_OK;
		hit = -1;
		case (w.action)
			fqr_pkg::ACT_ENQUEUE: begin
				if (held_records.size() >= QUEUE_DEPTH) begin
					r.status = fqr_pkg::ST_FULL;
				end else begin
					rec.id = w.proc_id;
					rec.prio = w.proc_priority;
					rec.pstate = w.proc_state;
					held_records.push_back(rec);
				end
			end
			fqr_pkg::ACT_DEQUEUE: begin
				if (held_records.size() == 0) begin
					r.status = fqr_pkg::ST_EMPTY;
				end else begin
					rec = held_records.pop_front();
					r.out_id = rec.id;
					r.out_priority = rec.prio;
					r.out_state = rec.pstate;
				end
			end
			fqr_pkg::ACT_REMOVE: begin
				// first match from the head goes, the rest keep their order
				for (int k = 0; k < held_records.size(); k++) begin
					if (held_records[k].id == w.proc_id) begin
						hit = k;
						break;
					end
				end
				if (hit < 0)
					r.status = fqr_pkg::ST_NOT_FOUND;
				else
					held_records.delete(hit);
			end
			default: ;
		endcase
		r.entry_count = 5'(held_records.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fqr_pkg::out_word_t want;
		if (!arst_n) begin
			held_records.delete();
			due_results.delete();
			errors <= 0;
			due_count <= 0;
			results_seen <= 0;
			full_hits <= 0;
			empty_hits <= 0;
			remove_hits <= 0;
			remove_misses <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				want = apply_word(req);
				due_results.push_back(want);
				if (want.status == fqr_pkg::ST_FULL)
					full_hits <= full_hits + 1;
				if (want.status == fqr_pkg::ST_EMPTY)
					empty_hits <= empty_hits + 1;
				if (req.action == fqr_pkg::ACT_REMOVE && want.status == fqr_pkg::ST_OK)
					remove_hits <= remove_hits + 1;
				if (want.status == fqr_pkg::ST_NOT_FOUND)
					remove_misses <= remove_misses + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				results_seen <= results_seen + 1;
				if (due_results.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("%0t: unexpected result word: status %0d id %h",
							$realtime, rsp.status, rsp.out_id);
				end else begin
					want = due_results.pop_front();
					if (rsp !== want) begin
						errors <= errors + 1;
						if (errors < 10) begin
							$display("%0t: result %0d differs", $realtime, results_seen);
							$display("  expected status %0d id %h prio %h state %0d count %0d",
								want.status, want.out_id, want.out_priority, want.out_state,
								want.entry_count);
							$display("  got      status %0d id %h prio %h state %0d count %0d",
								rsp.status, rsp.out_id, rsp.out_priority, rsp.out_state,
								rsp.entry_count);
						end
					end
				end
			end
			due_count <= due_results.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the record queue: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb;

	localparam int CLK_HALF     = 6;
	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 1750;
	localparam int DRAIN_CYCLES = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	fqr_pkg::in_word_t  req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	fqr_pkg::out_word_t rsp;

	int errors, due_count, results_seen, full_hits, empty_hits, remove_hits, remove_misses;
	int words_sent = 0;
	int idle_cycles = 0;
	bit hold_trigger = 1'b0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	fifo_queue_remove_by_id #(.QUEUE_DEPTH(fqr_pkg::QUEUE_DEPTH_DEF)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	record_queue_check #(.QUEUE_DEPTH(fqr_pkg::QUEUE_DEPTH_DEF)) i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.errors        (errors),
		.due_count     (due_count),
		.results_seen  (results_seen),
		.full_hits     (full_hits),
		.empty_hits    (empty_hits),
		.remove_hits   (remove_hits),
		.remove_misses (remove_misses)
	);

	// watchdog: ends the run when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: stall modes of random length, plus a long hold-off on request
	initial begin
		bit hold_seen;
		int hold_left;
		int mode;
		int mode_left;
		int tick;
		hold_seen = 1'b0;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 99) < 25);
					2: rsp_stall <= ($urandom_range(0, 99) < 70);
					default: rsp_stall <= (tick % 3 == 0);
				endcase
			end
		end
	end

	function automatic fqr_pkg::in_word_t make_word(input fqr_pkg::action_t a,
		input logic [15:0] id, input logic [7:0] p, input logic [1:0] s);
		fqr_pkg::in_word_t w;
		w.action = a;
		w.proc_id = id;
		w.proc_priority = p;
		w.proc_state = s;
		return w;
	endfunction

	// ids mostly from a small pool so removes hit and duplicates occur
	function automatic fqr_pkg::in_word_t random_word(input int enq_pct, input int deq_pct);
		int               r;
		fqr_pkg::action_t a;
		logic [15:0]      id;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 9) < 6)
			id = 16'($urandom_range(0, 11));
		else
			id = 16'($urandom_range(0, 65535));
		if (r < 3)
			a = fqr_pkg::ACT_NONE;
		else if (r < 3 + enq_pct)
			a = fqr_pkg::ACT_ENQUEUE;
		else if (r < 3 + enq_pct + deq_pct)
			a = fqr_pkg::ACT_DEQUEUE;
		else
			a = fqr_pkg::ACT_REMOVE;
		return make_word(a, id, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
	endfunction

	task automatic send_word(input fqr_pkg::in_word_t w);
		@(negedge clk);
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		words_sent++;
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	initial begin
		logic [15:0] id;
		int          phase;
		int          kind;
		int          len;
		int          burst_left;
		int          random_sent;
		bit          back2back;
		int          enq_pct;
		int          deq_pct;
		phase = 0;
		burst_left = 0;
		random_sent = 0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty cases, fill with extreme fields, overflow, removes
		send_word(make_word(fqr_pkg::ACT_DEQUEUE, 16'h0000, 8'h00, 2'd0));
		send_word(make_word(fqr_pkg::ACT_REMOVE, 16'h0000, 8'hFF, 2'd3));
		send_word(make_word(fqr_pkg::ACT_NONE, 16'hFFFF, 8'hFF, 2'd3));
		for (int i = 0; i < fqr_pkg::QUEUE_DEPTH_DEF; i++) begin
			if (i == 1)
				id = 16'hFFFF;
			else if (i == 3 || i == 9)
				id = 16'd5;
			else if (i == 15)
				id = 16'hABCD;
			else
				id = 16'(i * 16'h1111);
			send_word(make_word(fqr_pkg::ACT_ENQUEUE, id, 8'(i * 17), 2'(i)));
		end
		send_word(make_word(fqr_pkg::ACT_ENQUEUE, 16'h7777, 8'h55, 2'd1));
		send_word(make_word(fqr_pkg::ACT_REMOVE, 16'd5, 8'h00, 2'd0));
		send_word(make_word(fqr_pkg::ACT_REMOVE, 16'hABCD, 8'h00, 2'd0));
		send_word(make_word(fqr_pkg::ACT_REMOVE, 16'h1234, 8'h00, 2'd0));
		send_word(make_word(fqr_pkg::ACT_DEQUEUE, 16'h0000, 8'h00, 2'd0));
		send_word(make_word(fqr_pkg::ACT_NONE, 16'h0000, 8'h00, 2'd0));

		pause_sender(1);
		while (due_count != 0) @(negedge clk);

		// random phases: fill-heavy, drain-heavy, mixed, remove-heavy
		while (random_sent < RANDOM_WORDS) begin
			kind = phase % 4;
			len = $urandom_range(30, 120);
			back2back = ($urandom_range(0, 3) == 0);
			case (kind)
				0: begin enq_pct = 65; deq_pct = 12; end
				1: begin enq_pct = 20; deq_pct = 45; end
				2: begin enq_pct = 45; deq_pct = 20; end
				default: begin enq_pct = 40; deq_pct = 10; end
			endcase
			// long result hold-off while words keep coming, so the queue backs up
			if (phase == 2 || phase == 9)
				hold_trigger <= ~hold_trigger;
			if (phase % 5 == 4) begin
				pause_sender(1);
				while (due_count != 0) @(negedge clk);
			end
			for (int n = 0; n < len && random_sent < RANDOM_WORDS; n++) begin
				if (!back2back) begin
					if (burst_left == 0) begin
						pause_sender($urandom_range(1, 6));
						burst_left = $urandom_range(1, 24);
					end
					burst_left--;
				end
				send_word(random_word(enq_pct, deq_pct));
				random_sent++;
			end
			phase++;
		end

		pause_sender(1);
		while (due_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d words sent in %0d phases, %0d results checked, %0d bad",
			words_sent, phase, results_seen, errors);
		$display("Run: full %0d, dequeue on empty %0d, remove hit %0d, remove miss %0d",
			full_hits, empty_hits, remove_hits, remove_misses);
		if (errors == 0 && due_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
